### src/sxl_pkg.sv
`default_nettype none

package sxl_pkg;

    // Token length counter and register width
    localparam int unsigned LEN_W = 12;
    // Hard cap on the buffer size register
    localparam int unsigned MAX_TOKEN_LEN = 4095;
    // Result beats one input beat can cause
    localparam int unsigned MAX_RESULTS = 3;
    // Result queue depth
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
    // Reset value of the buffer size register
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd255;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        TOK_EOF    = 4'd0,
        TOK_LPAR   = 4'd1,
        TOK_RPAR   = 4'd2,
        TOK_DOT    = 4'd3,
        TOK_QUOTE  = 4'd4,
        TOK_STRING = 4'd5,
        TOK_INT    = 4'd6,
        TOK_SYMBOL = 4'd7,
        TOK_LABEL  = 4'd8
    } tok_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_TOO_LONG   = 2'd1,
        ERR_SPECIAL    = 2'd2,
        ERR_EOF_IN_STR = 2'd3
    } err_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       out_char;
        tok_t             token_type;
        logic [LEN_W-1:0] token_len;
        logic [63:0]      int_value;
        err_t             error_code;
        logic             last;
    } result_t;

    // One result beat, last cleared
    function automatic result_t make_result(kind_t k, logic [7:0] ch, tok_t tt,
                                            logic [LEN_W-1:0] len, logic [63:0] val,
                                            err_t err);
        result_t r;
        r.kind       = k;
        r.out_char   = ch;
        r.token_type = tt;
        r.token_len  = len;
        r.int_value  = val;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

### src/sxl_lexer.sv
`default_nettype none

// Lexer state and per-byte decode: one input beat in, up to three results out
module sxl_lexer (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_take,
    input  wire logic [7:0]                 in_char,
    input  wire logic                       is_end,
    input  wire logic [sxl_pkg::LEN_W-1:0]  limit,
    output logic [1:0]                      res_cnt,
    output sxl_pkg::result_t                res [sxl_pkg::MAX_RESULTS]
);

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_STRING  = 3'd1,
        M_ESCAPE  = 3'd2,
        M_COMMENT = 3'd3,
        M_NUMBER  = 3'd4,
        M_SYMBOL  = 3'd5
    } mode_t;

    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sym(logic [7:0] c);
        return (c >= CH_STAR) && (c <= CH_TILDE) && (c != CH_SEMI);
    endfunction

    mode_t                        mode_reg, mode_next;
    logic [sxl_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [7:0]                   first_reg, first_next;
    logic [63:0]                  acc_reg, acc_next;
    logic                         neg_reg, neg_next;
    logic                         sat_reg, sat_next;

    // acc * 10 + digit, top bits flag overflow past 2^64-1
    logic [67:0] acc_x10;
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                   + {64'b0, in_char[3:0] - CH_ZERO[3:0]};

    always_comb begin
        sxl_pkg::result_t     res_v [sxl_pkg::MAX_RESULTS];
        logic [1:0]           n_v;
        logic                 fin1;
        sxl_pkg::tok_t        fin1_type;
        logic [63:0]          fin1_val;
        logic                 do_idle;
        logic                 take_en;
        mode_t                mode_ok;
        logic                 fin2;
        sxl_pkg::tok_t        fin2_type;
        logic                 tail_en;
        sxl_pkg::result_t     tail_res;
        sxl_pkg::tok_t        sym_type;
        logic [63:0]          num_val;
        logic                 num_close;

        mode_next  = mode_reg;
        len_next   = len_reg;
        first_next = first_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        for (int i = 0; i < sxl_pkg::MAX_RESULTS; i++) begin
            res_v[i] = '0;
        end
        n_v       = 2'd0;
        fin1      = 1'b0;
        fin1_type = sxl_pkg::TOK_EOF;
        fin1_val  = '0;
        do_idle   = 1'b0;
        take_en   = 1'b0;
        mode_ok   = M_IDLE;
        fin2      = 1'b0;
        fin2_type = sxl_pkg::TOK_EOF;
        tail_en   = 1'b0;
        tail_res  = '0;

        sym_type  = (first_reg == CH_COLON) ? sxl_pkg::TOK_LABEL : sxl_pkg::TOK_SYMBOL;
        num_val   = sat_reg ? '1 : (neg_reg ? (64'd0 - acc_reg) : acc_reg);
        // a lone sign so far is a symbol, not a number
        num_close = (len_reg > sxl_pkg::LEN_W'(1)) || is_digit(first_reg);

        // Decode against the current mode
        if (is_end) begin
            tail_en  = 1'b1;
            tail_res = sxl_pkg::make_result(sxl_pkg::KIND_DONE, 8'd0, sxl_pkg::TOK_EOF,
                                            '0, '0, sxl_pkg::ERR_NONE);
            unique case (mode_reg)
                M_STRING, M_ESCAPE: begin
                    tail_res = sxl_pkg::make_result(sxl_pkg::KIND_ERROR, 8'd0,
                                                    sxl_pkg::TOK_EOF, '0, '0,
                                                    sxl_pkg::ERR_EOF_IN_STR);
                    mode_next = M_IDLE;
                end
                M_NUMBER: begin
                    fin1      = 1'b1;
                    fin1_type = num_close ? sxl_pkg::TOK_INT : sym_type;
                    fin1_val  = num_close ? num_val : '0;
                end
                M_SYMBOL: begin
                    fin1      = 1'b1;
                    fin1_type = sym_type;
                end
                default: begin
                    mode_next = M_IDLE;
                end
            endcase
        end else begin
            unique case (mode_reg)
                M_STRING: begin
                    if (in_char == CH_DQUOTE) begin
                        fin1      = 1'b1;
                        fin1_type = sxl_pkg::TOK_STRING;
                    end else begin
                        take_en = 1'b1;
                        mode_ok = (in_char == CH_BSLASH) ? M_ESCAPE : M_STRING;
                    end
                end
                M_ESCAPE: begin
                    take_en = 1'b1;
                    mode_ok = M_STRING;
                end
                M_COMMENT: begin
                    if (in_char == CH_LF) begin
                        mode_next = M_IDLE;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(in_char)) begin
                        if (!sat_reg) begin
                            if (acc_x10[67:64] != 4'd0) begin
                                sat_next = 1'b1;
                            end else begin
                                acc_next = acc_x10[63:0];
                            end
                        end
                        take_en = 1'b1;
                        mode_ok = M_NUMBER;
                    end else if (num_close) begin
                        fin1      = 1'b1;
                        fin1_type = sxl_pkg::TOK_INT;
                        fin1_val  = num_val;
                        do_idle   = 1'b1;
                    end else if (is_sym(in_char)) begin
                        mode_next = M_SYMBOL;
                        take_en   = 1'b1;
                        mode_ok   = M_SYMBOL;
                    end else begin
                        fin1      = 1'b1;
                        fin1_type = sym_type;
                        do_idle   = 1'b1;
                    end
                end
                M_SYMBOL: begin
                    if (is_sym(in_char)) begin
                        take_en = 1'b1;
                        mode_ok = M_SYMBOL;
                    end else begin
                        fin1      = 1'b1;
                        fin1_type = sym_type;
                        do_idle   = 1'b1;
                    end
                end
                default: begin
                    mode_next = M_IDLE;
                    do_idle   = 1'b1;
                end
            endcase
        end

        // Close the open token
        if (fin1) begin
            if (len_reg >= limit) begin
                res_v[n_v] = sxl_pkg::make_result(sxl_pkg::KIND_ERROR, 8'd0,
                                                  sxl_pkg::TOK_EOF, '0, '0,
                                                  sxl_pkg::ERR_TOO_LONG);
            end else begin
                res_v[n_v] = sxl_pkg::make_result(sxl_pkg::KIND_DONE, 8'd0, fin1_type,
                                                  len_reg, fin1_val, sxl_pkg::ERR_NONE);
            end
            n_v       = n_v + 2'd1;
            mode_next = M_IDLE;
        end

        // Byte seen from idle
        if (do_idle) begin
            if (in_char == CH_LPAR || in_char == CH_RPAR || in_char == CH_DOT ||
                in_char == CH_SQUOTE) begin
                len_next = '0;
                take_en  = 1'b1;
                mode_ok  = M_IDLE;
                fin2     = 1'b1;
                case (in_char)
                    CH_LPAR: fin2_type = sxl_pkg::TOK_LPAR;
                    CH_RPAR: fin2_type = sxl_pkg::TOK_RPAR;
                    CH_DOT:  fin2_type = sxl_pkg::TOK_DOT;
                    default: fin2_type = sxl_pkg::TOK_QUOTE;
                endcase
            end else if (in_char == CH_DQUOTE) begin
                len_next  = '0;
                mode_next = M_STRING;
            end else if (in_char == CH_SEMI) begin
                mode_next = M_COMMENT;
            end else if (is_digit(in_char) || in_char == CH_MINUS || in_char == CH_PLUS) begin
                len_next   = '0;
                first_next = in_char;
                sat_next   = 1'b0;
                neg_next   = (in_char == CH_MINUS);
                acc_next   = is_digit(in_char) ? {60'd0, in_char[3:0]} : '0;
                take_en    = 1'b1;
                mode_ok    = M_NUMBER;
            end else if (is_sym(in_char)) begin
                len_next   = '0;
                first_next = in_char;
                take_en    = 1'b1;
                mode_ok    = M_SYMBOL;
            end else if (in_char >= CH_BANG && in_char <= CH_SQUOTE) begin
                tail_en  = 1'b1;
                tail_res = sxl_pkg::make_result(sxl_pkg::KIND_ERROR, 8'd0,
                                                sxl_pkg::TOK_EOF, '0, '0,
                                                sxl_pkg::ERR_SPECIAL);
            end
        end

        // Append one token character, or fail on the length limit
        if (take_en) begin
            if (len_next >= limit) begin
                res_v[n_v] = sxl_pkg::make_result(sxl_pkg::KIND_ERROR, 8'd0,
                                                  sxl_pkg::TOK_EOF, '0, '0,
                                                  sxl_pkg::ERR_TOO_LONG);
                mode_next  = M_IDLE;
                fin2       = 1'b0;
            end else begin
                res_v[n_v] = sxl_pkg::make_result(sxl_pkg::KIND_CHAR, in_char,
                                                  sxl_pkg::TOK_EOF, '0, '0,
                                                  sxl_pkg::ERR_NONE);
                len_next   = len_next + sxl_pkg::LEN_W'(1);
                mode_next  = mode_ok;
            end
            n_v = n_v + 2'd1;
        end

        // Single-character token completes at once
        if (fin2) begin
            if (len_next >= limit) begin
                res_v[n_v] = sxl_pkg::make_result(sxl_pkg::KIND_ERROR, 8'd0,
                                                  sxl_pkg::TOK_EOF, '0, '0,
                                                  sxl_pkg::ERR_TOO_LONG);
            end else begin
                res_v[n_v] = sxl_pkg::make_result(sxl_pkg::KIND_DONE, 8'd0, fin2_type,
                                                  len_next, '0, sxl_pkg::ERR_NONE);
            end
            n_v       = n_v + 2'd1;
            mode_next = M_IDLE;
        end

        // End-of-input token or a closing error
        if (tail_en) begin
            res_v[n_v] = tail_res;
            n_v        = n_v + 2'd1;
        end

        if (n_v != 2'd0) begin
            res_v[n_v - 2'd1].last = 1'b1;
        end

        res     = res_v;
        res_cnt = n_v;
    end

    // State advances only on an accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            len_reg   <= '0;
            first_reg <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            sat_reg   <= 1'b0;
        end else if (in_take) begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            first_reg <= first_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            sat_reg   <= sat_next;
        end
    end

endmodule

`default_nettype wire

### src/sxl_res_queue.sv
`default_nettype none

// Small result queue: up to 3 beats in at once, one out per ready cycle
module sxl_res_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [1:0]        push_cnt,
    input  wire sxl_pkg::result_t  push_data [sxl_pkg::MAX_RESULTS],
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sxl_pkg::result_t       out_data
);

    sxl_pkg::result_t                 mem [sxl_pkg::QUEUE_DEPTH];
    logic [sxl_pkg::QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [sxl_pkg::QCNT_W-1:0]       cnt_reg;
    logic                             pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a worst-case burst once the head beat is counted
    assign room      = (cnt_reg <= sxl_pkg::QCNT_W'(sxl_pkg::QUEUE_DEPTH - sxl_pkg::MAX_RESULTS));

    // Entry storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < sxl_pkg::MAX_RESULTS; i++) begin
            if (2'(i) < push_cnt) begin
                mem[wr_ptr_reg + sxl_pkg::QPTR_W'(i)] <= push_data[i];
            end
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + sxl_pkg::QPTR_W'(push_cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + sxl_pkg::QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + sxl_pkg::QCNT_W'(push_cnt)
                     - sxl_pkg::QCNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

### src/s_expression_lexer.sv
`default_nettype none

// Lisp lexer. Each input beat carries one source byte, or an end-of-input
// mark on s_tuser. Each beat is decoded in the cycle it is accepted and its
// results (token characters, completed tokens, errors; at most three) go
// into a four-entry result queue that drives the output one beat per cycle
// while m_tready is high. A byte with one result or none is taken every
// cycle while m_tready is high; s_tready is high while the queue holds at
// most one beat, so a byte that closes a token and starts another (up to
// three results) holds off the input while the queue drains. The token
// length limit is written on cfg_wr_en and must only be changed while the
// block is idle.
module s_expression_lexer (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // buffer size register
    input  wire logic          cfg_wr_en,
    input  wire logic [11:0]   cfg_wr_data,
    // input channel
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] in_char
    input  wire logic          s_tuser,   // is_end
    // result channel
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [95:0]        m_tdata,   // [7:0] out_char, [11:8] token_type,
                                          // [23:12] token_len, [87:24] int_value,
                                          // [89:88] error_code, [95:90] zero
    output logic [1:0]         m_tuser,   // kind
    output logic               m_tlast    // last result of the input beat
);

    logic [sxl_pkg::LEN_W-1:0]  max_len_reg;
    logic [sxl_pkg::LEN_W-1:0]  limit;
    logic                       in_take;
    logic [1:0]                 res_cnt;
    sxl_pkg::result_t           res [sxl_pkg::MAX_RESULTS];
    sxl_pkg::result_t           head;

    // Buffer size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= sxl_pkg::MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Token may hold at most limit-1 characters
    assign limit = (32'(max_len_reg) > sxl_pkg::MAX_TOKEN_LEN)
                 ? sxl_pkg::LEN_W'(sxl_pkg::MAX_TOKEN_LEN) : max_len_reg;

    assign in_take = s_tvalid && s_tready;

    sxl_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (in_take),
        .in_char (s_tdata),
        .is_end  (s_tuser),
        .limit   (limit),
        .res_cnt (res_cnt),
        .res     (res)
    );

    sxl_res_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (in_take ? res_cnt : 2'd0),
        .push_data (res),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // Output beat packing
    assign m_tdata = {6'd0, head.error_code, head.int_value, head.token_len,
                      head.token_type, head.out_char};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

`default_nettype wire
